// ===== hdl/gbn_pkg.sv =====
// Shared types, constants and helpers for the go-back-n window core.
// No dependencies; every other file imports this package.

package gbn_pkg;

   localparam int MAX_SEQUENCE    = 7;
   localparam int SEQ_SPACE       = MAX_SEQUENCE + 1;
   localparam int SEQ_W           = 3;
   localparam int CNT_W           = 4;
   localparam int PAYLOAD_WIDTH   = 16;
   localparam int TIMEOUT_W       = 16;
   localparam int TIMER_WIDTH_DEF = 16;
   localparam int KIND_W          = 3;
   localparam int CMD_W           = 2;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

   typedef enum logic [CMD_W-1:0] {
      CMD_SEND   = 2'd0,
      CMD_ARRIVE = 2'd1,
      CMD_CKERR  = 2'd2,
      CMD_TICK   = 2'd3
   } cmd_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_TX      = 3'd0,
      KIND_RETX    = 3'd1,
      KIND_DELIVER = 3'd2,
      KIND_RELEASE = 3'd3,
      KIND_REFUSE  = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_RELEASE,
      ST_RESEND
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_SEND,
      OP_REFUSE,
      OP_DELIVER,
      OP_RELEASE,
      OP_TICK,
      OP_RESEND
   } op_type;

   // controller -> datapath
   typedef struct packed {
      logic   load;
      op_type op;
      logic   last;
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      cmd_type cmd;
      logic    in_order;
      logic    window_full;
      logic    rel_more;
      logic    rel_last;
      logic    expired;
      logic    buf_nonzero;
      logic    rs_last;
      logic    out_free;
   } ctl_stat_type;

   // a <= b < c, taken circularly
   function automatic logic circ_between(input logic [SEQ_W-1:0] a,
                                         input logic [SEQ_W-1:0] b,
                                         input logic [SEQ_W-1:0] c);
      return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
   endfunction

   function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
      return (s == SEQ_W'(MAX_SEQUENCE)) ? '0 : SEQ_W'(s + 1'b1);
   endfunction

   function automatic logic is_emit(input op_type op);
      return (op != OP_NONE) && (op != OP_TICK);
   endfunction

endpackage

// ===== hdl/gbn_req_if.sv =====
// Request channel: command items into the window core.
// Depends on gbn_pkg for field widths.

interface gbn_req_if import gbn_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         cmd;
   logic [PAYLOAD_WIDTH-1:0] payload;
   logic [SEQ_W-1:0]         rx_seq;
   logic [SEQ_W-1:0]         rx_ack;

   modport source (output valid, cmd, payload, rx_seq, rx_ack, input ready);
   modport sink   (input valid, cmd, payload, rx_seq, rx_ack, output ready);
endinterface

// ===== hdl/gbn_rsp_if.sv =====
// Response channel: result items out of the window core.
// Depends on gbn_pkg for field widths.

interface gbn_rsp_if import gbn_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        kind;
   logic [SEQ_W-1:0]         seq_out;
   logic [SEQ_W-1:0]         ack_out;
   logic [PAYLOAD_WIDTH-1:0] payload_out;
   logic                     last;

   modport source (output valid, kind, seq_out, ack_out, payload_out, last, input ready);
   modport sink   (input valid, kind, seq_out, ack_out, payload_out, last, output ready);
endinterface

// ===== hdl/gbn_ctrl.sv =====
// Sequencing state machine of the window core: decode, ack release loop, resend loop.
// Depends on gbn_pkg; drives gbn_dp through ctl_cmd_type.

module gbn_ctrl import gbn_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ctl_stat_type stat,
   output ctl_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '{load: 1'b0, op: OP_NONE, last: 1'b0};
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (stat.cmd)
               CMD_SEND: begin
                  if (stat.out_free) begin
                     cmd.op   = stat.window_full ? OP_REFUSE : OP_SEND;
                     cmd.last = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
               CMD_ARRIVE: begin
                  // deliver first, then walk the released frames
                  if (stat.in_order) begin
                     if (stat.out_free) begin
                        cmd.op   = OP_DELIVER;
                        cmd.last = !stat.rel_more;
                        state_in = stat.rel_more ? ST_RELEASE : ST_IDLE;
                     end
                  end else begin
                     state_in = stat.rel_more ? ST_RELEASE : ST_IDLE;
                  end
               end
               CMD_TICK: begin
                  cmd.op   = OP_TICK;
                  state_in = (stat.expired && stat.buf_nonzero) ? ST_RESEND : ST_IDLE;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_RELEASE: begin
            if (stat.out_free) begin
               cmd.op   = OP_RELEASE;
               cmd.last = stat.rel_last;
               if (stat.rel_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_RESEND: begin
            if (stat.out_free) begin
               cmd.op   = OP_RESEND;
               cmd.last = stat.rs_last;
               if (stat.rs_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (is_emit(cmd.op) && cmd.last) |=> (state_ff == ST_IDLE))
      else $error("item did not end after its last result");

   a_resend_has_frames: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESEND) |-> stat.buf_nonzero)
      else $error("resend loop running with an empty window");

endmodule

// ===== hdl/gbn_dp.sv =====
// Datapath of the window core: sequence counters, frame store, timers, output register.
// Depends on gbn_pkg; commanded by gbn_ctrl.

module gbn_dp import gbn_pkg::*; #(
   parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [CMD_W-1:0]         req_cmd,
   input  logic [PAYLOAD_WIDTH-1:0] req_payload,
   input  logic [SEQ_W-1:0]         req_rx_seq,
   input  logic [SEQ_W-1:0]         req_rx_ack,
   input  logic                     csr_we,
   input  logic [TIMEOUT_W-1:0]     csr_wdata,
   input  ctl_cmd_type              cmd,
   output ctl_stat_type             stat,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [KIND_W-1:0]        rsp_kind,
   output logic [SEQ_W-1:0]         rsp_seq_out,
   output logic [SEQ_W-1:0]         rsp_ack_out,
   output logic [PAYLOAD_WIDTH-1:0] rsp_payload_out,
   output logic                     rsp_last
);

   localparam int CMP_W = (TIMER_WIDTH > TIMEOUT_W) ? TIMER_WIDTH : TIMEOUT_W;

   // latched request
   cmd_type                  cmd_ff;
   logic [PAYLOAD_WIDTH-1:0] pay_ff;
   logic [SEQ_W-1:0]         rseq_ff;
   logic [SEQ_W-1:0]         rack_ff;

   // window state
   logic [SEQ_W-1:0]         nts_ff;
   logic [SEQ_W-1:0]         oldest_ff;
   logic [SEQ_W-1:0]         expected_ff;
   logic [CNT_W-1:0]         buf_ff;
   logic [TIMEOUT_W-1:0]     timeout_ff;
   logic [SEQ_W-1:0]         rs_ptr_ff;
   logic [CNT_W-1:0]         rs_left_ff;

   logic [PAYLOAD_WIDTH-1:0] frame_mem [SEQ_SPACE];

   logic [TIMER_WIDTH-1:0]   tmr_ff  [SEQ_SPACE];
   logic [TIMER_WIDTH-1:0]   tmr_inc [SEQ_SPACE];
   logic [SEQ_SPACE-1:0]     tmr_run_ff;
   logic [SEQ_SPACE-1:0]     tmr_hit;

   logic                     rsp_valid_ff;
   logic [KIND_W-1:0]        kind_ff;
   logic [SEQ_W-1:0]         seq_out_ff;
   logic [SEQ_W-1:0]         ack_out_ff;
   logic [PAYLOAD_WIDTH-1:0] pay_out_ff;
   logic                     last_ff;

   logic                     emit;
   logic [SEQ_W-1:0]         piggy_ack;
   logic [SEQ_W-1:0]         oldest_next;

   assign emit        = is_emit(cmd.op);
   assign piggy_ack   = SEQ_W'(expected_ff + SEQ_W'(MAX_SEQUENCE));
   assign oldest_next = seq_inc(oldest_ff);

   // saturating increment and expiry compare, one per timer
   always_comb begin
      for (int i = 0; i < SEQ_SPACE; i++) begin
         tmr_inc[i] = (tmr_ff[i] == {TIMER_WIDTH{1'b1}}) ? tmr_ff[i]
                                                        : TIMER_WIDTH'(tmr_ff[i] + 1'b1);
         tmr_hit[i] = tmr_run_ff[i] && (CMP_W'(tmr_inc[i]) >= CMP_W'(timeout_ff));
      end
   end

   always_comb begin
      stat.cmd         = cmd_ff;
      stat.in_order    = (rseq_ff == expected_ff);
      stat.window_full = (buf_ff >= CNT_W'(MAX_SEQUENCE));
      stat.rel_more    = (buf_ff != '0) && circ_between(oldest_ff, rack_ff, nts_ff);
      stat.rel_last    = !((buf_ff > CNT_W'(1)) && circ_between(oldest_next, rack_ff, nts_ff));
      stat.expired     = |tmr_hit;
      stat.buf_nonzero = (buf_ff != '0);
      stat.rs_last     = (rs_left_ff == CNT_W'(1));
      stat.out_free    = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff  <= cmd_type'(req_cmd);
         pay_ff  <= req_payload;
         rseq_ff <= req_rx_seq;
         rack_ff <= req_rx_ack;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_we) begin
         timeout_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nts_ff      <= '0;
         oldest_ff   <= '0;
         expected_ff <= '0;
         buf_ff      <= '0;
         rs_ptr_ff   <= '0;
         rs_left_ff  <= '0;
      end else begin
         unique case (cmd.op)
            OP_SEND: begin
               nts_ff <= seq_inc(nts_ff);
               buf_ff <= CNT_W'(buf_ff + 1'b1);
            end
            OP_DELIVER: begin
               expected_ff <= seq_inc(expected_ff);
            end
            OP_RELEASE: begin
               oldest_ff <= oldest_next;
               buf_ff    <= CNT_W'(buf_ff - 1'b1);
            end
            OP_TICK: begin
               // arm the resend walk from the oldest outstanding frame
               rs_ptr_ff  <= oldest_ff;
               rs_left_ff <= buf_ff;
            end
            OP_RESEND: begin
               rs_ptr_ff  <= seq_inc(rs_ptr_ff);
               rs_left_ff <= CNT_W'(rs_left_ff - 1'b1);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_SEND) begin
         frame_mem[nts_ff] <= pay_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SEQ_SPACE; i++) begin
            tmr_ff[i]     <= '0;
            tmr_run_ff[i] <= 1'b0;
         end
      end else begin
         for (int i = 0; i < SEQ_SPACE; i++) begin
            if (cmd.op == OP_TICK && tmr_run_ff[i]) begin
               tmr_ff[i] <= tmr_inc[i];
            end
            if (cmd.op == OP_SEND && nts_ff == SEQ_W'(i)) begin
               tmr_ff[i]     <= '0;
               tmr_run_ff[i] <= 1'b1;
            end
            if (cmd.op == OP_RELEASE && oldest_ff == SEQ_W'(i)) begin
               tmr_ff[i]     <= '0;
               tmr_run_ff[i] <= 1'b0;
            end
            if (cmd.op == OP_RESEND && rs_ptr_ff == SEQ_W'(i)) begin
               tmr_ff[i] <= '0;
            end
         end
      end
   end

   // output register: hold until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         last_ff <= cmd.last;
         unique case (cmd.op)
            OP_SEND: begin
               kind_ff    <= KIND_TX;
               seq_out_ff <= nts_ff;
               ack_out_ff <= piggy_ack;
               pay_out_ff <= pay_ff;
            end
            OP_RESEND: begin
               kind_ff    <= KIND_RETX;
               seq_out_ff <= rs_ptr_ff;
               ack_out_ff <= piggy_ack;
               pay_out_ff <= frame_mem[rs_ptr_ff];
            end
            OP_DELIVER: begin
               kind_ff    <= KIND_DELIVER;
               seq_out_ff <= rseq_ff;
               ack_out_ff <= '0;
               pay_out_ff <= pay_ff;
            end
            OP_RELEASE: begin
               kind_ff    <= KIND_RELEASE;
               seq_out_ff <= oldest_ff;
               ack_out_ff <= '0;
               pay_out_ff <= '0;
            end
            default: begin
               kind_ff    <= KIND_REFUSE;
               seq_out_ff <= '0;
               ack_out_ff <= '0;
               pay_out_ff <= '0;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_seq_out     = seq_out_ff;
   assign rsp_ack_out     = ack_out_ff;
   assign rsp_payload_out = pay_out_ff;
   assign rsp_last        = last_ff;

   a_window_span: assert property (@(posedge clock) disable iff (reset)
      (buf_ff <= CNT_W'(MAX_SEQUENCE)) &&
      (SEQ_W'(nts_ff - oldest_ff) == buf_ff[SEQ_W-1:0]))
      else $error("outstanding count disagrees with window pointers");

   a_timers_match_window: assert property (@(posedge clock) disable iff (reset)
      $countones(tmr_run_ff) == int'(buf_ff))
      else $error("running timers do not match outstanding frames");

   a_emit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an untaken result");

endmodule

// ===== hdl/go_back_n_sliding_window_core.sv =====
// Go-back-N endpoint with a 3-bit sequence space, top level.
// Usage: drive command items on req_chan (send, frame arrival, checksum error,
// tick); results leave on rsp_chan, each flagged by last if it ends its item.
// Kinds: transmit, retransmit, in-order deliver, ack released, refused (window full).
// The user writes the timeout in ticks on csr_we/csr_wdata only while no item
// is in flight; the block itself does not enforce it. An accepted item is
// latched and decoded in the next cycle; its first result is loaded into the
// output register once that register is free. Items pass one at a time through
// the control state machine; the release loop and the resend loop walk one
// frame a cycle while the output is free, and an arrival that delivers nothing,
// like an expiring tick, goes from decode straight to its release or resend loop.
// A new item is taken as soon as the last result sits in the output register,
// even while it waits there. A stalled receiver freezes the loops.
// Reset (synchronous, active high) empties the window, stops all timers and
// restores the timeout to 1000 ticks; the frame store holds no reset value.

module go_back_n_sliding_window_core import gbn_pkg::*; #(
   parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   gbn_req_if.sink              req_chan,
   gbn_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  logic [TIMEOUT_W-1:0] csr_wdata
);

   ctl_cmd_type  ctl_cmd;
   ctl_stat_type ctl_stat;

   gbn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (ctl_stat),
      .cmd       (ctl_cmd)
   );

   gbn_dp #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_chan.cmd),
      .req_payload     (req_chan.payload),
      .req_rx_seq      (req_chan.rx_seq),
      .req_rx_ack      (req_chan.rx_ack),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .cmd             (ctl_cmd),
      .stat            (ctl_stat),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_kind        (rsp_chan.kind),
      .rsp_seq_out     (rsp_chan.seq_out),
      .rsp_ack_out     (rsp_chan.ack_out),
      .rsp_payload_out (rsp_chan.payload_out),
      .rsp_last        (rsp_chan.last)
   );

endmodule
